>>> src/m4p_pkg.sv
// ----------------------------------------------------------------------------
// m4p_pkg
// action codes, widths and the determinant sequencer's term table
// ----------------------------------------------------------------------------
package m4p_pkg;

    localparam int DIGIT_MOD = 10;
    localparam int DIM       = 4;
    localparam int VAL_W     = 18;

    typedef enum logic [3:0] {
        ACT_LOADA     = 4'd0,
        ACT_LOADB     = 4'd1,
        ACT_INC       = 4'd2,
        ACT_DEC       = 4'd3,
        ACT_MUL       = 4'd4,
        ACT_ADD       = 4'd5,
        ACT_SUB       = 4'd6,
        ACT_DET       = 4'd7,
        ACT_TRANSPOSE = 4'd8,
        ACT_ROWMIN    = 4'd9,
        ACT_COLMAX    = 4'd10
    } action_t;

    localparam logic [1:0] SRC_A    = 2'd0;
    localparam logic [1:0] SRC_B    = 2'd1;
    localparam logic [1:0] SRC_BOTH = 2'd2;

    // one determinant term: sign and column of rows 0..3 (a permutation)
    typedef struct packed {
        logic       neg;
        logic [1:0] c0;
        logic [1:0] c1;
        logic [1:0] c2;
        logic [1:0] c3;
    } det_term_t;

    // the 24 permutations of the leibniz expansion, equal to cofactor form
    function automatic det_term_t det_term(input logic [4:0] idx);
        det_term_t t;
        t = '0;
        unique case (idx)
            5'd0:  t = '{1'b0, 2'd0, 2'd1, 2'd2, 2'd3};
            5'd1:  t = '{1'b1, 2'd0, 2'd1, 2'd3, 2'd2};
            5'd2:  t = '{1'b1, 2'd0, 2'd2, 2'd1, 2'd3};
            5'd3:  t = '{1'b0, 2'd0, 2'd2, 2'd3, 2'd1};
            5'd4:  t = '{1'b0, 2'd0, 2'd3, 2'd1, 2'd2};
            5'd5:  t = '{1'b1, 2'd0, 2'd3, 2'd2, 2'd1};
            5'd6:  t = '{1'b1, 2'd1, 2'd0, 2'd2, 2'd3};
            5'd7:  t = '{1'b0, 2'd1, 2'd0, 2'd3, 2'd2};
            5'd8:  t = '{1'b0, 2'd1, 2'd2, 2'd0, 2'd3};
            5'd9:  t = '{1'b1, 2'd1, 2'd2, 2'd3, 2'd0};
            5'd10: t = '{1'b1, 2'd1, 2'd3, 2'd0, 2'd2};
            5'd11: t = '{1'b0, 2'd1, 2'd3, 2'd2, 2'd0};
            5'd12: t = '{1'b0, 2'd2, 2'd0, 2'd1, 2'd3};
            5'd13: t = '{1'b1, 2'd2, 2'd0, 2'd3, 2'd1};
            5'd14: t = '{1'b1, 2'd2, 2'd1, 2'd0, 2'd3};
            5'd15: t = '{1'b0, 2'd2, 2'd1, 2'd3, 2'd0};
            5'd16: t = '{1'b0, 2'd2, 2'd3, 2'd0, 2'd1};
            5'd17: t = '{1'b1, 2'd2, 2'd3, 2'd1, 2'd0};
            5'd18: t = '{1'b1, 2'd3, 2'd0, 2'd1, 2'd2};
            5'd19: t = '{1'b0, 2'd3, 2'd0, 2'd2, 2'd1};
            5'd20: t = '{1'b0, 2'd3, 2'd1, 2'd0, 2'd2};
            5'd21: t = '{1'b1, 2'd3, 2'd1, 2'd2, 2'd0};
            5'd22: t = '{1'b1, 2'd3, 2'd2, 2'd0, 2'd1};
            5'd23: t = '{1'b0, 2'd3, 2'd2, 2'd1, 2'd0};
            default: t = '0;
        endcase
        return t;
    endfunction

endpackage

>>> src/matrix4_pair_unit.sv
// ----------------------------------------------------------------------------
// matrix4_pair_unit
// two 4x4 digit matrices with a shared step unit for matrix commands
// ----------------------------------------------------------------------------
// loads complete on the accept; inc/dec then sweep the store of both matrices (one entry a cycle)
// mul: per element, 3 multiply-accumulate steps, the 4th product added on emit
// det: 24 terms per matrix (4 multiply steps, 1 add each), then an emit
// add, sub, transposed elements: a read step then emit; rowmin, colmax: a compare pass then emit, per result
// one item at a time, not ready while busy; output register holds a result until taken
// reset (rst_n low, async): both matrices cleared to zero, sequencer idle
module matrix4_pair_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // action[3:0], row[5:4], col[7:6], digit[11:8], zeros
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // out_row[1:0], out_col[3:2], out_value[21:4], zeros
    output logic [3:0]  m_tuser,   // source[1:0], is_det[2], zeros
    output logic        m_tlast
);

    localparam int VAL_W_L = m4p_pkg::VAL_W;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SWEEP = 5'b00010,  // inc/dec pass over the store
        ST_READ  = 5'b00100,  // one step of the shared unit: multiply, accumulate or compare
        ST_CALC  = 5'b01000,  // add or subtract one determinant term
        ST_EMIT  = 5'b10000   // wait for output register free
    } state_t;

    state_t state_reg, state_next;

    // matrix store: A at 0..15, B at 16..31; flops, read through a mux
    logic [3:0] mem_reg [32];

    logic [3:0]  act_reg;
    logic [4:0]  idx_reg;          // sweep / term index
    logic        mat_reg;          // which matrix for per-matrix commands
    logic [3:0]  pos_reg;          // element position r*4+c
    logic [1:0]  k_reg;            // inner step
    logic signed [VAL_W_L-1:0] acc_reg;
    logic signed [VAL_W_L-1:0] prod_reg;
    logic [3:0]  ext_reg;          // running min/max
    logic        det_phase_reg;    // det phase: set for det, and for transpose after its element run

    logic              ov_reg;
    logic [1:0]        osrc_reg, orow_reg, ocol_reg;
    logic              odet_reg, olast_reg;
    logic signed [VAL_W_L-1:0] oval_reg;

    logic [3:0] in_act;
    logic [1:0] in_row, in_col;
    logic [3:0] in_dig;
    assign in_act = s_tdata[3:0];
    assign in_row = s_tdata[5:4];
    assign in_col = s_tdata[7:6];
    assign in_dig = s_tdata[11:8];

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ov_reg;
    assign m_tdata  = {2'b00, oval_reg, ocol_reg, orow_reg};
    assign m_tuser  = {1'b0, odet_reg, osrc_reg};
    assign m_tlast  = olast_reg;

    wire out_free = !ov_reg || m_tready;
    wire [1:0] r = pos_reg[3:2];
    wire [1:0] c = pos_reg[1:0];
    m4p_pkg::det_term_t term;
    assign term = m4p_pkg::det_term(idx_reg);

    // operand selection for the shared unit
    logic [4:0] addr_a, addr_b;
    logic [1:0] dcol;
    always_comb
    begin
        unique case (k_reg)
            2'd0: dcol = term.c0;
            2'd1: dcol = term.c1;
            2'd2: dcol = term.c2;
            default: dcol = term.c3;
        endcase
        addr_a = {mat_reg, r, c};
        addr_b = {1'b1, r, c};
        unique case (act_reg)
            m4p_pkg::ACT_MUL:
            begin
                addr_a = {1'b0, r, k_reg};
                addr_b = {1'b1, k_reg, c};
            end
            m4p_pkg::ACT_DET, m4p_pkg::ACT_TRANSPOSE:
            begin
                // transposed det equals det; read row k, column from term
                addr_a = {mat_reg, k_reg, dcol};
                if (act_reg == m4p_pkg::ACT_TRANSPOSE && !det_phase_reg)
                    addr_a = {mat_reg, c, r};
            end
            m4p_pkg::ACT_ROWMIN: addr_a = {mat_reg, r, k_reg};
            m4p_pkg::ACT_COLMAX: addr_a = {mat_reg, k_reg, c};
            default: ;
        endcase
    end

    logic [3:0] va, vb, vs;
    always_comb
    begin
        va = mem_reg[addr_a];
        vb = mem_reg[addr_b];
        vs = mem_reg[{mat_reg, pos_reg}];
    end

    // shared unit: one small multiply by a digit, accumulate or compare
    logic signed [VAL_W_L-1:0] mul_in;
    logic signed [VAL_W_L-1:0] mul_out;
    always_comb
    begin
        mul_in = (act_reg == m4p_pkg::ACT_MUL) ? VAL_W_L'(signed'({1'b0, vb}))
                 : ((k_reg == 2'd0) ? VAL_W_L'(1) : prod_reg);
        mul_out = VAL_W_L'(mul_in * signed'({1'b0, va}));
    end

    wire is_det_act = (act_reg == m4p_pkg::ACT_DET) ||
                      (act_reg == m4p_pkg::ACT_TRANSPOSE && det_phase_reg);

    // commands whose results combine both matrices
    wire pair_act = (act_reg == m4p_pkg::ACT_MUL) || (act_reg == m4p_pkg::ACT_ADD) ||
                    (act_reg == m4p_pkg::ACT_SUB);

    // the result being emitted ends the command
    wire emit_last = is_det_act ? mat_reg
                     : (pos_reg == 4'd15 && act_reg != m4p_pkg::ACT_TRANSPOSE &&
                        (mat_reg || pair_act));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg <= 1'b0;
            for (int i = 0; i < 32; i++)
                mem_reg[i] <= '0;
            act_reg <= '0;
            idx_reg <= '0;
            mat_reg <= 1'b0;
            pos_reg <= '0;
            k_reg <= '0;
            acc_reg <= '0;
            prod_reg <= '0;
            ext_reg <= '0;
            det_phase_reg <= 1'b0;
            osrc_reg <= '0;
            orow_reg <= '0;
            ocol_reg <= '0;
            odet_reg <= 1'b0;
            olast_reg <= 1'b0;
            oval_reg <= '0;
        end
        else
        begin
            if (state_reg == ST_EMIT && out_free)
                ov_reg <= 1'b1;
            else if (m_tready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (s_tvalid)
                    begin
                        act_reg <= in_act;
                        idx_reg <= '0;
                        mat_reg <= 1'b0;
                        pos_reg <= '0;
                        k_reg <= '0;
                        det_phase_reg <= (in_act == m4p_pkg::ACT_DET);
                        acc_reg <= '0;
                        if (in_act == m4p_pkg::ACT_LOADA || in_act == m4p_pkg::ACT_LOADB)
                            mem_reg[{in_act[0], in_row, in_col}] <=
                                (in_dig > 4'd9) ? 4'd9 : in_dig;
                        else if (in_act == m4p_pkg::ACT_INC || in_act == m4p_pkg::ACT_DEC)
                            state_reg <= ST_SWEEP;
                        else if (in_act >= m4p_pkg::ACT_MUL &&
                                 in_act <= m4p_pkg::ACT_COLMAX)
                            state_reg <= ST_READ;
                    end
                ST_SWEEP:
                begin
                    if (act_reg == m4p_pkg::ACT_INC)
                        mem_reg[idx_reg] <= (mem_reg[idx_reg] == 4'd9) ? 4'd0
                                            : mem_reg[idx_reg] + 4'd1;
                    else
                        mem_reg[idx_reg] <= (mem_reg[idx_reg] == 4'd0) ? 4'd9
                                            : mem_reg[idx_reg] - 4'd1;
                    idx_reg <= idx_reg + 5'd1;
                    if (idx_reg == 5'd31)
                        state_reg <= ST_IDLE;
                end
                ST_READ:
                begin
                    // per-element steps of the shared unit
                    priority case (1'b1)
                        (act_reg == m4p_pkg::ACT_MUL):
                        begin
                            // the fourth product is added on emit
                            acc_reg <= acc_reg + mul_out;
                            k_reg <= k_reg + 2'd1;
                            if (k_reg == 2'd2)
                                state_reg <= ST_EMIT;
                        end
                        is_det_act:
                        begin
                            prod_reg <= mul_out;
                            k_reg <= k_reg + 2'd1;
                            if (k_reg == 2'd3)
                                state_reg <= ST_CALC;
                        end
                        (act_reg == m4p_pkg::ACT_ROWMIN):
                        begin
                            if (k_reg == 2'd0 || va < ext_reg)
                                ext_reg <= va;
                            k_reg <= k_reg + 2'd1;
                            if (k_reg == 2'd3)
                                state_reg <= ST_EMIT;
                        end
                        (act_reg == m4p_pkg::ACT_COLMAX):
                        begin
                            if (k_reg == 2'd0 || va > ext_reg)
                                ext_reg <= va;
                            k_reg <= k_reg + 2'd1;
                            if (k_reg == 2'd3)
                                state_reg <= ST_EMIT;
                        end
                        default:
                            state_reg <= ST_EMIT;   // add, sub, transpose element
                    endcase
                end
                ST_CALC:
                begin
                    acc_reg <= term.neg ? acc_reg - prod_reg : acc_reg + prod_reg;
                    idx_reg <= idx_reg + 5'd1;
                    state_reg <= (idx_reg == 5'd23) ? ST_EMIT : ST_READ;
                end
                ST_EMIT:
                    if (out_free)
                    begin
                        odet_reg <= is_det_act;
                        osrc_reg <= pair_act ? m4p_pkg::SRC_BOTH
                                    : (mat_reg ? m4p_pkg::SRC_B : m4p_pkg::SRC_A);
                        orow_reg <= is_det_act ? 2'd0 : r;
                        ocol_reg <= is_det_act ? 2'd0 : c;
                        olast_reg <= emit_last;
                        k_reg <= '0;
                        acc_reg <= '0;
                        idx_reg <= '0;
                        state_reg <= emit_last ? ST_IDLE : ST_READ;
                        priority case (1'b1)
                            (act_reg == m4p_pkg::ACT_MUL):
                                oval_reg <= acc_reg + mul_out;
                            (act_reg == m4p_pkg::ACT_ADD):
                                oval_reg <= VAL_W_L'(va) + VAL_W_L'(vb);
                            (act_reg == m4p_pkg::ACT_SUB):
                                oval_reg <= VAL_W_L'(va) - VAL_W_L'(vb);
                            is_det_act:
                                oval_reg <= acc_reg;
                            (act_reg == m4p_pkg::ACT_ROWMIN):
                                oval_reg <= VAL_W_L'(vs) - VAL_W_L'(ext_reg);
                            (act_reg == m4p_pkg::ACT_COLMAX):
                                oval_reg <= VAL_W_L'(vs) + VAL_W_L'(ext_reg);
                            default:
                                oval_reg <= VAL_W_L'(va);   // transposed element
                        endcase
                        // advance position / matrix
                        if (is_det_act)
                        begin
                            pos_reg <= '0;
                            mat_reg <= 1'b1;
                            if (act_reg == m4p_pkg::ACT_TRANSPOSE)
                                det_phase_reg <= 1'b0;
                        end
                        else if (pos_reg == 4'd15)
                        begin
                            pos_reg <= '0;
                            if (act_reg == m4p_pkg::ACT_TRANSPOSE)
                                det_phase_reg <= 1'b1;
                            else if (!emit_last)
                                mat_reg <= 1'b1;
                        end
                        else
                            pos_reg <= pos_reg + 4'd1;
                    end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> src/m4p_checker.sv
// ----------------------------------------------------------------------------
// m4p_checker
// port-level checks of the matrix unit
// ----------------------------------------------------------------------------
module m4p_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic [3:0]  m_tuser,
    input logic        m_tlast
);

    // result held while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed under stall");

    // a determinant has row and column zero
    a_det_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> m_tdata[3:0] == 4'd0)
        else $error("determinant with nonzero position");

    // no source code 3
    a_src: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser[1:0] != 2'd3)
        else $error("bad source");

    // not ready while a result run is still unfinished
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("ready during a result run");

endmodule

bind matrix4_pair_unit m4p_checker u_m4p_checker (.*);
